### rtl/dtd_pkg.sv
`default_nettype none

package dtd_pkg;

	localparam int MAX_TASKS  = 8;
	localparam int TASK_W     = $clog2(MAX_TASKS);
	localparam int CNT_W      = 4;
	localparam int DEP_W      = MAX_TASKS * MAX_TASKS;
	localparam int CFG_W      = DEP_W;
	localparam int TDATA_W    = 8;
	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	localparam logic             REG_DEP_MASKS    = 1'b0;
	localparam logic             REG_TASK_COUNT   = 1'b1;
	localparam logic [DEP_W-1:0] DEP_MASKS_RESET  = 64'h0017_0307_0000_0000;
	localparam logic [CNT_W-1:0] TASK_COUNT_RESET = 4'd7;

	localparam logic FUNC_START    = 1'b0;
	localparam logic FUNC_COMPLETE = 1'b1;

	typedef enum logic [1:0] {
		TS_PENDING,
		TS_EXECUTING,
		TS_PASSED
	} task_state_t;

	typedef enum logic [1:0] {
		KIND_DISPATCH,
		KIND_OK,
		KIND_DONE,
		KIND_ERROR
	} result_kind_t;

	typedef enum logic [1:0] {
		EV_START,
		EV_COMPLETE,
		EV_BAD
	} event_kind_t;

	typedef struct packed {
		event_kind_t        kind;
		logic [TASK_W-1:0]  idx;
	} event_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_EVAL,
		BK_EMIT
	} back_state_t;

	// active count is the count register clamped to the number of task slots
	function automatic logic [CNT_W-1:0] active_count(input logic [CNT_W-1:0] cnt);
		logic [CNT_W-1:0] n;
		n = cnt;
		if (cnt > CNT_W'(MAX_TASKS))
			n = CNT_W'(MAX_TASKS);
		return n;
	endfunction

	function automatic logic [MAX_TASKS-1:0] use_mask(input logic [CNT_W-1:0] n);
		logic [MAX_TASKS-1:0] m;
		for (int i = 0; i < MAX_TASKS; i++)
			m[i] = CNT_W'(i) < n;
		return m;
	endfunction

endpackage

`default_nettype wire

### rtl/dtd_front.sv
`default_nettype none

module dtd_front (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	input  wire logic [dtd_pkg::TDATA_W-1:0] s_tdata,   // task_index
	input  wire logic                        s_tuser,   // func
	input  wire logic [dtd_pkg::CNT_W-1:0]   n,
	output logic                             ev_valid,
	output dtd_pkg::event_t                  ev,
	input  wire logic                        ev_pop
);
	import dtd_pkg::*;

	event_t                  fifo_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0]   wr_ptr_q;
	logic [FIFO_PTR_W-1:0]   rd_ptr_q;
	logic [FIFO_CNT_W-1:0]   count_q;
	event_t                  cls;
	logic                    push;

	// classify the incoming word against the active task count
	always_comb begin
		cls.idx  = s_tdata[TASK_W-1:0];
		cls.kind = EV_COMPLETE;
		if (s_tuser == FUNC_START) begin
			cls.kind = EV_START;
			cls.idx  = '0;
		end else if ({1'b0, s_tdata[TASK_W-1:0]} >= n) begin
			cls.kind = EV_BAD;
		end
	end

	assign s_tready = count_q != FIFO_CNT_W'(FIFO_DEPTH);
	assign push     = s_tvalid && s_tready;
	assign ev_valid = count_q != '0;
	assign ev       = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			fifo_q[wr_ptr_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (ev_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, ev_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

### rtl/dtd_back.sv
`default_nettype none

module dtd_back (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        ev_valid,
	input  wire dtd_pkg::event_t             ev,
	output logic                             ev_pop,
	input  wire logic [dtd_pkg::DEP_W-1:0]   dep_masks,
	input  wire logic [dtd_pkg::CNT_W-1:0]   n,
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	output logic [dtd_pkg::TDATA_W-1:0]      m_tdata,   // dispatch_index
	output logic [1:0]                       m_tuser,   // kind
	output logic                             m_tlast
);
	import dtd_pkg::*;

	back_state_t            state_q, state_d;
	task_state_t            ts_q [MAX_TASKS];
	task_state_t            ts_d [MAX_TASKS];
	task_state_t            st_upd [MAX_TASKS];
	event_t                 ev_q;
	logic [MAX_TASKS-1:0]   emit_q, emit_d;
	result_kind_t           status_q, status_d;
	logic                   out_valid_q;
	result_kind_t           out_kind_q, out_kind_d;
	logic [TASK_W-1:0]      out_idx_q, out_idx_d;
	logic                   out_last_q, out_last_d;
	logic                   out_load;
	logic                   out_free;
	logic [MAX_TASKS-1:0]   use_m;
	logic [MAX_TASKS-1:0]   deps [MAX_TASKS];
	logic [MAX_TASKS-1:0]   rdy_start, rdy_cmp, passed, exec_vec;
	logic                   all_passed;
	logic [TASK_W-1:0]      low_idx;

	assign use_m    = use_mask(n);
	assign out_free = !out_valid_q || m_tready;

	// per-task readiness lanes
	always_comb begin
		for (int i = 0; i < MAX_TASKS; i++) begin
			deps[i]      = dep_masks[i*MAX_TASKS +: MAX_TASKS] & use_m;
			st_upd[i]    = (ev_q.idx == TASK_W'(i)) ? TS_PASSED : ts_q[i];
			passed[i]    = use_m[i] && (st_upd[i] == TS_PASSED);
			rdy_start[i] = use_m[i] && (deps[i] == '0);
			exec_vec[i]  = ts_q[i] == TS_EXECUTING;
		end
		for (int i = 0; i < MAX_TASKS; i++)
			rdy_cmp[i] = use_m[i] && (st_upd[i] == TS_PENDING)
				&& ((deps[i] & ~passed) == '0);
		all_passed = passed == use_m;
	end

	// lowest pending dispatch
	always_comb begin
		low_idx = '0;
		for (int i = MAX_TASKS - 1; i >= 0; i--)
			if (emit_q[i])
				low_idx = TASK_W'(i);
	end

	always_comb begin
		state_d    = state_q;
		ts_d       = ts_q;
		emit_d     = emit_q;
		status_d   = status_q;
		ev_pop     = 1'b0;
		out_load   = 1'b0;
		out_kind_d = out_kind_q;
		out_idx_d  = out_idx_q;
		out_last_d = out_last_q;
		unique case (state_q)
			BK_IDLE: begin
				if (ev_valid) begin
					ev_pop  = 1'b1;
					state_d = BK_EVAL;
				end
			end
			BK_EVAL: begin
				state_d = BK_EMIT;
				case (ev_q.kind)
					EV_START: begin
						for (int i = 0; i < MAX_TASKS; i++)
							ts_d[i] = rdy_start[i] ? TS_EXECUTING : TS_PENDING;
						emit_d   = rdy_start;
						status_d = KIND_OK;
					end
					EV_COMPLETE: begin
						for (int i = 0; i < MAX_TASKS; i++)
							ts_d[i] = (rdy_cmp[i] && !all_passed) ? TS_EXECUTING : st_upd[i];
						if (all_passed) begin
							emit_d   = '0;
							status_d = KIND_DONE;
						end else begin
							emit_d   = rdy_cmp;
							status_d = KIND_OK;
						end
					end
					default: begin
						emit_d   = '0;
						status_d = KIND_ERROR;
					end
				endcase
			end
			BK_EMIT: begin
				if (out_free) begin
					out_load = 1'b1;
					if (emit_q != '0) begin
						out_kind_d = KIND_DISPATCH;
						out_idx_d  = low_idx;
						out_last_d = 1'b0;
						emit_d     = emit_q & (emit_q - 1'b1);
					end else begin
						out_kind_d = status_q;
						out_idx_d  = '0;
						out_last_d = 1'b1;
						state_d    = BK_IDLE;
					end
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			emit_q      <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < MAX_TASKS; i++)
				ts_q[i] <= TS_PENDING;
		end else begin
			state_q <= state_d;
			emit_q  <= emit_d;
			ts_q    <= ts_d;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ev_pop)
			ev_q <= ev;
		status_q <= status_d;
		if (out_load) begin
			out_kind_q <= out_kind_d;
			out_idx_q  <= out_idx_d;
			out_last_q <= out_last_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(TDATA_W-TASK_W){1'b0}}, out_idx_q};
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;

	a_last_is_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_last_q == (out_kind_q != KIND_DISPATCH)))
		else $error("last flag does not match result kind");

	a_emit_only_executing: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_EMIT) |-> ((emit_q & ~exec_vec) == '0))
		else $error("queued dispatch for a task not executing");

	a_eval_after_pop: assert property (@(posedge clk) disable iff (!arst_n)
		ev_pop |=> (state_q == BK_EVAL))
		else $error("popped event not evaluated");

	a_dispatch_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_kind_q == KIND_DISPATCH)) |-> use_m[out_idx_q])
		else $error("dispatch of a task outside the count");

endmodule

`default_nettype wire

### rtl/dependency_task_dispatcher_core.sv
// dependency task dispatcher
// slave stream: one word per event; s_tuser is the event kind (0 start, 1 task
// completed), s_tdata[2:0] the completed task. master stream: one word per
// result; m_tuser is the result kind (0 dispatch, 1 ok, 2 all done, 3 error),
// m_tdata[2:0] the dispatched task, m_tlast marks the status word ending an
// event. configuration: cfg_we with cfg_index 0 writes the 64-bit dependency
// masks, index 1 the 4-bit task count; write only while idle.
// events pass through a two-word queue to the scheduler, which takes one event
// at a time: a pop state, then an evaluate state that checks all tasks in
// parallel, then one result word per cycle while the master is ready.
// reset clears all tasks to pending, empties the queue and restores the
// register defaults. a stalled master holds the current word; the queue
// keeps accepting until both entries are full.
`default_nettype none

module dependency_task_dispatcher_core (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	input  wire logic [dtd_pkg::TDATA_W-1:0] s_tdata,   // task_index
	input  wire logic                        s_tuser,   // func
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	output logic [dtd_pkg::TDATA_W-1:0]      m_tdata,   // dispatch_index
	output logic [1:0]                       m_tuser,   // kind
	output logic                             m_tlast,
	input  wire logic                        cfg_we,
	input  wire logic                        cfg_index,
	input  wire logic [dtd_pkg::CFG_W-1:0]   cfg_data
);
	import dtd_pkg::*;

	logic [DEP_W-1:0]  dep_masks_q;
	logic [CNT_W-1:0]  task_count_q;
	logic [CNT_W-1:0]  n;
	logic              ev_valid;
	logic              ev_pop;
	event_t            ev;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dep_masks_q  <= DEP_MASKS_RESET;
			task_count_q <= TASK_COUNT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DEP_MASKS:  dep_masks_q  <= cfg_data[DEP_W-1:0];
				REG_TASK_COUNT: task_count_q <= cfg_data[CNT_W-1:0];
				default:        dep_masks_q  <= dep_masks_q;
			endcase
		end
	end

	assign n = active_count(task_count_q);

	dtd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.n        (n),
		.ev_valid (ev_valid),
		.ev       (ev),
		.ev_pop   (ev_pop)
	);

	dtd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.ev_valid  (ev_valid),
		.ev        (ev),
		.ev_pop    (ev_pop),
		.dep_masks (dep_masks_q),
		.n         (n),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

`default_nettype wire
